// ===== rtl/lru_page_replacement_top_defines.svh =====
// Assertion macros for the port-level checker of the LRU page replacement block.
// Depends on nothing; included by the checker file.
`ifndef LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_TOP_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define LRU_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define LRU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lru_pr_pkg.sv =====
// Package for the LRU page replacement block: fixed field widths, reset values
// and the flag struct passed from the frame search to the top level. No dependencies.
`timescale 1ns / 1ps

package lru_pr_pkg;

  localparam int CFG_W      = 5;
  localparam int SLOT_OUT_W = 4;
  localparam int FAULT_W    = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd16;

  typedef logic [CFG_W-1:0]   cfg_frames_t;
  typedef logic [FAULT_W-1:0] fault_t;

  // Outcome of the frame search for one access.
  typedef struct packed {
    logic hit;
    logic empty;
  } sel_flags_t;

endpackage

// ===== rtl/lru_pr_ifs.sv =====
// Valid/ready channel interfaces for page accesses and replacement results.
// Depends on lru_pr_pkg for the fixed result field widths.
`timescale 1ns / 1ps

interface lru_req_if #(
  parameter int PAGE_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink (input valid, input page_number, output ready);
  modport monitor (input valid, input page_number, input ready);
endinterface

interface lru_rsp_if
  import lru_pr_pkg::*;
#(
  parameter int PAGE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [SLOT_OUT_W-1:0] frame_slot;
  logic                  evicted_valid;
  logic [PAGE_BITS-1:0]  evicted_page;
  fault_t                fault_total;

  modport source (output valid, output hit, output frame_slot, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink (input valid, input hit, input frame_slot, input evicted_valid,
                input evicted_page, input fault_total, output ready);
  modport monitor (input valid, input hit, input frame_slot, input evicted_valid,
                   input evicted_page, input fault_total, input ready);
endinterface

// ===== rtl/lru_pr_select.sv =====
// Frame search for the LRU block: parallel page match, lowest empty frame and
// a comparison tree that finds the oldest frame. Depends on lru_pr_pkg.
`timescale 1ns / 1ps

module lru_pr_select
  import lru_pr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  parameter int SLOT_W     = 4
) (
  input  logic [PAGE_BITS-1:0]  page,
  input  logic [PAGE_BITS-1:0]  page_store [MAX_FRAMES],
  input  logic [MAX_FRAMES-1:0] slot_valid,
  input  logic [SLOT_W-1:0]     rank [MAX_FRAMES],
  input  logic [MAX_FRAMES-1:0] active,
  output sel_flags_t            flags,
  output logic [SLOT_W-1:0]     slot
);

  localparam int LVL    = $clog2(MAX_FRAMES);
  localparam int LEAVES = 1 << LVL;

  logic [MAX_FRAMES-1:0] match;
  logic [MAX_FRAMES-1:0] empty;
  logic [SLOT_W-1:0]     hit_slot;
  logic [SLOT_W-1:0]     empty_slot;

  logic              node_ok   [2*LEAVES];
  logic [SLOT_W-1:0] node_rank [2*LEAVES];
  logic [SLOT_W-1:0] node_idx  [2*LEAVES];

  always_comb begin
    hit_slot   = '0;
    empty_slot = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      match[i] = active[i] && slot_valid[i] && (page_store[i] == page);
      empty[i] = active[i] && !slot_valid[i];
    end
    // Scan downward so that the lowest index wins.
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = SLOT_W'(i);
      end
      if (empty[i]) begin
        empty_slot = SLOT_W'(i);
      end
    end
  end

  // Heap-ordered tree: leaves sit at LEAVES+i, the root at node 1. On equal
  // ranks the left (lower index) side is kept.
  always_comb begin
    node_ok[0]   = 1'b0;
    node_rank[0] = '0;
    node_idx[0]  = '0;
    for (int i = 0; i < LEAVES; i++) begin
      node_idx[LEAVES+i] = SLOT_W'(i);
      if (i < MAX_FRAMES) begin
        node_ok[LEAVES+i]   = active[i];
        node_rank[LEAVES+i] = rank[i];
      end else begin
        node_ok[LEAVES+i]   = 1'b0;
        node_rank[LEAVES+i] = '0;
      end
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      if (node_ok[2*k] && (!node_ok[2*k+1] || node_rank[2*k] >= node_rank[2*k+1])) begin
        node_ok[k]   = node_ok[2*k];
        node_rank[k] = node_rank[2*k];
        node_idx[k]  = node_idx[2*k];
      end else begin
        node_ok[k]   = node_ok[2*k+1];
        node_rank[k] = node_rank[2*k+1];
        node_idx[k]  = node_idx[2*k+1];
      end
    end
  end

  always_comb begin
    flags.hit   = |match;
    flags.empty = |empty;
    if (flags.hit) begin
      slot = hit_slot;
    end else if (flags.empty) begin
      slot = empty_slot;
    end else begin
      slot = node_idx[1];
    end
  end

endmodule

// ===== rtl/lru_page_replacement_top.sv =====
// Top level of the LRU page replacement block: input register, frame state,
// rank update and result register. Depends on lru_pr_pkg, lru_pr_ifs, lru_pr_select.
`timescale 1ns / 1ps
//
//  Channel   Dir  Handshake      Contents
//  req       in   valid/ready    page_number
//  rsp       out  valid/ready    hit, frame_slot, evicted_valid, evicted_page, fault_total
//  cfg       in   cfg_wr_en      cfg_wr_data = frames_in_use
//
//  An access moves from the input register to the result register, so the block takes one
//  transfer per cycle while rsp is not stalled; the frame search and rank update sit in that
//  stage. Synchronous reset empties all frames, clears ranks and the fault count and sets
//  frames_in_use to 16. When rsp is stalled the result holds and req takes one more access.

module lru_page_replacement_top
  import lru_pr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  cfg_frames_t      cfg_wr_data,
  lru_req_if.sink          req,
  lru_rsp_if.source        rsp
);

  localparam int SLOT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [SLOT_W-1:0] RANK_MAX = SLOT_W'(MAX_FRAMES - 1);

  cfg_frames_t           cfg_frames;
  logic                  in_valid;
  logic [PAGE_BITS-1:0]  in_page;
  logic [PAGE_BITS-1:0]  page_store [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] slot_valid;
  logic [SLOT_W-1:0]     rank [MAX_FRAMES];
  logic [SLOT_W-1:0]     rank_next [MAX_FRAMES];
  fault_t                fault_count;
  fault_t                fault_count_next;
  logic                  out_valid;

  logic [7:0]            active_count;
  logic [MAX_FRAMES-1:0] active;
  sel_flags_t            flags;
  logic [SLOT_W-1:0]     slot;
  logic [SLOT_W-1:0]     old_rank;
  logic                  age_all;
  logic                  advance;
  logic [SLOT_W+3:0]     slot_wide;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign rsp.valid = out_valid;

  // A count of zero behaves as one; counts above the frame total are clipped.
  always_comb begin
    if (cfg_frames == '0) begin
      active_count = 8'd1;
    end else if ({3'b000, cfg_frames} > 8'(MAX_FRAMES)) begin
      active_count = 8'(MAX_FRAMES);
    end else begin
      active_count = {3'b000, cfg_frames};
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      active[i] = 8'(i) < active_count;
    end
  end

  lru_pr_select #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .SLOT_W     (SLOT_W)
  ) u_select (
    .page       (in_page),
    .page_store (page_store),
    .slot_valid (slot_valid),
    .rank       (rank),
    .active     (active),
    .flags      (flags),
    .slot       (slot)
  );

  // Frames younger than the touched one age by one; filling an empty frame ages
  // every full active frame.
  always_comb begin
    old_rank = rank[slot];
    age_all  = !flags.hit && flags.empty;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_next[i] = rank[i];
      if (active[i] && slot_valid[i] && (SLOT_W'(i) != slot) &&
          (age_all || rank[i] < old_rank) && (rank[i] < RANK_MAX)) begin
        rank_next[i] = rank[i] + 1'b1;
      end
    end
    rank_next[slot] = '0;
  end

  always_comb begin
    fault_count_next = fault_count;
    if (!flags.hit && (fault_count != '1)) begin
      fault_count_next = fault_count + 1'b1;
    end
  end

  assign slot_wide = {4'b0000, slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_frames  <= FRAMES_RESET;
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      slot_valid  <= '0;
      fault_count <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        cfg_frames <= cfg_wr_data;
      end
      if (req.valid && req.ready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        fault_count <= fault_count_next;
        rank        <= rank_next;
        if (!flags.hit) begin
          slot_valid[slot] <= 1'b1;
        end
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_page <= req.page_number;
    end
    if (advance) begin
      if (!flags.hit) begin
        page_store[slot] <= in_page;
      end
      rsp.hit           <= flags.hit;
      rsp.frame_slot    <= slot_wide[SLOT_OUT_W-1:0];
      rsp.evicted_valid <= !flags.hit && !flags.empty;
      rsp.evicted_page  <= (!flags.hit && !flags.empty) ? page_store[slot] : '0;
      rsp.fault_total   <= fault_count_next;
    end
  end

endmodule

// ===== rtl/lru_pr_chk.sv =====
// Port-level checker for the LRU page replacement top level, with its bind.
// Depends on lru_pr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lru_page_replacement_top_defines.svh"

module lru_pr_chk
  import lru_pr_pkg::*;
#(
  parameter int PAGE_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_hit,
  input logic [SLOT_OUT_W-1:0] rsp_frame_slot,
  input logic [PAGE_BITS-1:0]  rsp_evicted_page,
  input fault_t                rsp_fault_total
);

  // No result is offered in the cycle after reset.
  `LRU_ASSERT_ALWAYS(a_no_rsp_after_rst, clk, $past(rst) |-> !rsp_valid, "result valid after reset")

  // A stalled result keeps its contents.
  `LRU_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_frame_slot) && $stable(rsp_evicted_page) && $stable(rsp_fault_total), "stalled result changed")

  // Back pressure on req only arises from a full, stalled result register.
  `LRU_ASSERT(a_req_stall_cause, clk, rst, !req_ready |-> rsp_valid && !rsp_ready, "req stalled without rsp back pressure")

  // Consecutive results advance the fault count by one per miss, saturating.
  `LRU_ASSERT(a_fault_step, clk, rst, (rsp_valid && rsp_ready) ##1 (rsp_valid && rsp_ready) |-> rsp_fault_total == (($past(rsp_fault_total) == '1) ? $past(rsp_fault_total) : $past(rsp_fault_total) + FAULT_W'(!rsp_hit)), "fault count step wrong")

endmodule

bind lru_page_replacement_top lru_pr_chk #(
  .PAGE_BITS (PAGE_BITS)
) u_chk (
  .clk              (clk),
  .rst              (rst),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_hit          (rsp.hit),
  .rsp_frame_slot   (rsp.frame_slot),
  .rsp_evicted_page (rsp.evicted_page),
  .rsp_fault_total  (rsp.fault_total)
);

// ===== test/lru_page_replacement_checker.sv =====
// Checker for the LRU page replacement block: watches the access, result and frame-count
// ports, keeps its own copy of the frame state and compares every result transfer.
// Depends on lru_pr_pkg and the channel interfaces in lru_pr_ifs.
`timescale 1ns / 1ps

module lru_page_replacement_checker
  import lru_pr_pkg::*;
#(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  cfg_frames_t cfg_wr_data,
  lru_req_if.monitor  req,
  lru_rsp_if.monitor  rsp,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [RANK_W-1:0] OLDEST_RANK = RANK_W'(MAX_FRAMES - 1);

  typedef struct {
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    fault_t                faults;
  } access_result_t;

  logic [PAGE_BITS-1:0] frame_page [MAX_FRAMES];
  logic                 frame_full [MAX_FRAMES];
  logic [RANK_W-1:0]    frame_rank [MAX_FRAMES];
  fault_t               fault_count;
  cfg_frames_t          frames_cfg;

  access_result_t pending_results[$];

  function automatic int unsigned active_count();
    int unsigned n;
    n = 32'(frames_cfg);
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  // Frame s becomes the newest; full frames newer than its old rank age by one step.
  function automatic void make_recent(int unsigned n, int unsigned s, int unsigned old_rank);
    for (int unsigned i = 0; i < n; i++) begin
      if (i != s && frame_full[i] && frame_rank[i] < old_rank && frame_rank[i] < OLDEST_RANK)
        frame_rank[i] = frame_rank[i] + 1'b1;
    end
    frame_rank[s] = '0;
  endfunction

  function automatic access_result_t access_page(logic [PAGE_BITS-1:0] pg);
    access_result_t res;
    int unsigned    n;
    int unsigned    slot;
    int unsigned    best;
    logic           found;
    logic           empty;
    n     = active_count();
    slot  = 0;
    found = 1'b0;
    empty = 1'b0;
    res.evicted_valid = 1'b0;
    res.evicted_page  = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (!found && frame_full[i] && frame_page[i] == pg) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (found) begin
      make_recent(n, slot, 32'(frame_rank[slot]));
    end else begin
      for (int unsigned i = 0; i < n; i++) begin
        if (!empty && !frame_full[i]) begin
          empty = 1'b1;
          slot  = i;
        end
      end
      if (empty) begin
        make_recent(n, slot, 32'hFFFF_FFFF);
      end else begin
        // Oldest rank wins; on a tie the lowest index stays chosen.
        best = 0;
        slot = 0;
        for (int unsigned i = 0; i < n; i++) begin
          if (i == 0 || 32'(frame_rank[i]) > best) begin
            best = 32'(frame_rank[i]);
            slot = i;
          end
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frame_page[slot];
        make_recent(n, slot, 32'(frame_rank[slot]));
      end
      frame_page[slot] = pg;
      frame_full[slot] = 1'b1;
      if (fault_count != '1) fault_count = fault_count + 1'b1;
    end
    res.hit    = found;
    res.slot   = SLOT_OUT_W'(slot);
    res.faults = fault_count;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    access_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        frame_page[i] = '0;
        frame_full[i] = 1'b0;
        frame_rank[i] = '0;
      end
      fault_count = '0;
      frames_cfg  = FRAMES_RESET;
      mismatches  = 0;
      pending_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no access pending");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, rsp.hit);
            mismatches++;
          end
          if (rsp.frame_slot !== want.slot) begin
            $error("frame_slot: expected %0d, actual %0d", want.slot, rsp.frame_slot);
            mismatches++;
          end
          if (rsp.evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d, actual %0d", want.evicted_valid,
                   rsp.evicted_valid);
            mismatches++;
          end
          if (rsp.evicted_page !== want.evicted_page) begin
            $error("evicted_page: expected %h, actual %h", want.evicted_page,
                   rsp.evicted_page);
            mismatches++;
          end
          if (rsp.fault_total !== want.faults) begin
            $error("fault_total: expected %0d, actual %0d", want.faults, rsp.fault_total);
            mismatches++;
          end
        end
      end
      if (cfg_wr_en) frames_cfg = cfg_wr_data;
      if (req.valid && req.ready) pending_results.push_back(access_page(req.page_number));
    end
    outstanding = pending_results.size();
  end

endmodule

// ===== test/lru_page_replacement_top_tb.sv =====
// Testbench top for the LRU page replacement block: clock, reset, page access stimulus,
// frame-count phases and result back-pressure; the checker module does the comparison.
// Depends on lru_pr_pkg, lru_pr_ifs, lru_page_replacement_top and the checker.
`timescale 1ns / 1ps

module lru_page_replacement_top_tb;
  import lru_pr_pkg::*;

  localparam int MAX_FRAMES   = 16;
  localparam int PAGE_BITS    = 16;
  localparam int PHASE_ITEMS  = 98;
  localparam int POOL_SIZE    = 24;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AT      = 450;
  localparam int HOLD_CYCLES  = 64;
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 800;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  cfg_frames_t cfg_wr_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned sent_count = 0;
  int unsigned got_count  = 0;
  int unsigned settings_done = 0;
  int          cycles = 0;

  logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

  // Fill all sixteen frames, hit on a resident page, then force evictions.
  logic [PAGE_BITS-1:0] directed_pages [22] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'h0002, 16'h0003,
    16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 16'h0009, 16'h000A, 16'h000B,
    16'h000C, 16'hFFFF, 16'h1234, 16'h0000, 16'h5555, 16'hAAAA
  };

  // Zero acts as one frame, values above sixteen act as sixteen.
  cfg_frames_t frame_settings [10] = '{
    5'd1, 5'd0, 5'd31, 5'd4, 5'd16, 5'd17, 5'd8, 5'd2, 5'd12, 5'd16
  };

  lru_req_if #(.PAGE_BITS(PAGE_BITS)) req_ch ();
  lru_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_ch ();

  lru_page_replacement_top #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  lru_page_replacement_checker #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) got_count <= got_count + 1;
  end

  // Result side: random stalls, one long hold-off while accesses keep coming, and a
  // calm window with no stalls.
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
        rsp_ch.ready <= 1'b0;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1;
      end else if (sent_count >= CALM_FIRST && sent_count < CALM_LAST) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 11);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Mostly pages from a shared pool so hits and duplicate residency occur; the rest
  // are fully random pages, all-zero and all-one pages and single-bit set or cleared patterns.
  function automatic logic [PAGE_BITS-1:0] pick_page();
    int                   r;
    int                   k;
    logic [PAGE_BITS-1:0] p;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, PAGE_BITS - 1);
    if (r < 65) p = page_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (r < 85) p = PAGE_BITS'($urandom());
    else if (r < 90) p = '0;
    else if (r < 95) p = '1;
    else if (r < 98) p = PAGE_BITS'(1) << k;
    else p = ~(PAGE_BITS'(1) << k);
    return p;
  endfunction

  task automatic send_page(input logic [PAGE_BITS-1:0] pg);
    while (!(sent_count >= CALM_FIRST && sent_count < CALM_LAST) &&
           $urandom_range(0, 99) < 11) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.page_number <= pg;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
  endtask

  // The frame count is only changed once every result has drained.
  task automatic set_frames(input cfg_frames_t value);
    req_ch.valid <= 1'b0;
    while (got_count != sent_count) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_done++;
  endtask

  initial begin : stimulus
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = FRAMES_RESET;
    req_ch.valid       = 1'b0;
    req_ch.page_number = '0;
    foreach (page_pool[i]) page_pool[i] = PAGE_BITS'($urandom());
    page_pool[0] = '0;
    page_pool[1] = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_pages[i]) send_page(directed_pages[i]);
    foreach (frame_settings[s]) begin
      set_frames(frame_settings[s]);
      repeat (PHASE_ITEMS) send_page(pick_page());
    end
    req_ch.valid <= 1'b0;
    while (got_count != sent_count) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Covered %0d page accesses and %0d results over the reset frame count",
             sent_count, got_count);
    $display("and %0d written frame counts, including zero, one, sixteen and above.",
             settings_done);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
